>>> hw/rtl/sspan_pkg.sv
package sspan_pkg;

  localparam int DataW  = 8;
  localparam int CoordW = 17;
  localparam int KindW  = 3;
  localparam int OutW   = 48;

  localparam logic [KindW-1:0] KIND_HEADER  = 3'd0;
  localparam logic [KindW-1:0] KIND_PIXEL   = 3'd1;
  localparam logic [KindW-1:0] KIND_ROW_END = 3'd2;
  localparam logic [KindW-1:0] KIND_IMG_END = 3'd3;
  localparam logic [KindW-1:0] KIND_BAD_SIG = 3'd4;
  localparam logic [KindW-1:0] KIND_BAD_SZ  = 3'd5;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [DataW-1:0]  pix;
  } result_t;

endpackage

>>> hw/rtl/sparse_span_image_decoder.sv
// Channel  | Dir | Handshake         | Payload (lowest bits first)
// s_*      | in  | s_tvalid/s_tready | tdata: data_byte; tuser: first_of_file
// m_*      | out | m_tvalid/m_tready | tdata: row, column, pixel; tuser: kind
// cfg_*    | in  | cfg_we            | cfg_wdata: word_big_endian
//
// One input byte is taken per cycle while s_tready is high; each byte yields zero or one result item.
// A result is registered, into the output or the skid register, at the edge that accepts its byte.
// A two-entry output stage (output register plus skid register) keeps input
// flowing while a result waits; s_tready drops only while the skid is full.
// rst is synchronous: header phase, empty output stage, little-endian byte order.
module sparse_span_image_decoder import sspan_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DataW-1:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]        s_tuser,   // [0] first_of_file
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OutW-1:0]   m_tdata,   // [16:0] row_index, [33:17] column_index,
                                       // [41:34] pixel_value, [47:42] zero
  output logic [KindW-1:0]  m_tuser,   // [2:0] kind
  input  logic              cfg_we,
  input  logic              cfg_wdata  // word_big_endian
);

  logic    big_endian;
  logic    acc_in;
  logic    take_out;
  logic    res_valid;
  result_t res;
  logic    out_valid;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;

  // Byte order register; the user must write it only while the decoder is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b0;
    end else if (cfg_we) begin
      big_endian <= cfg_wdata;
    end
  end

  assign s_tready = !skid_valid;
  assign acc_in   = s_tvalid && s_tready;
  assign take_out = out_valid && m_tready;

  sspan_parse u_parse (
    .clk             (clk),
    .rst             (rst),
    .step            (acc_in),
    .data_byte       (s_tdata),
    .first_of_file   (s_tuser[0]),
    .word_big_endian (big_endian),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Control of the output stage: advance the skid into the output register
  // when the output is taken, park a new result in the skid when a full output is not taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take_out) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= acc_in && res_valid;
        end
      end else if (acc_in && res_valid) begin
        if (out_valid) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // Payload registers: hold unless loaded.
  always_ff @(posedge clk) begin
    if (take_out) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (acc_in && res_valid) begin
        out_res <= res;
      end
    end else if (acc_in && res_valid) begin
      if (out_valid) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tdata  = {{(OutW - 2 * CoordW - DataW){1'b0}}, out_res.pix, out_res.col,
                     out_res.row};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an item while the output register is empty");

  a_skid_advance: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> (out_valid && !skid_valid))
    else $error("skid item not advanced after output was taken");

  a_skid_park: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready && acc_in && res_valid) |=> skid_valid)
    else $error("result lost while output stalled");

endmodule

>>> hw/rtl/sspan_parse.sv
module sspan_parse import sspan_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [DataW-1:0] data_byte,
  input  logic             first_of_file,
  input  logic             word_big_endian,
  output logic             res_valid,
  output result_t          res
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_TABLE  = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_RUN    = 3'd3;
  localparam logic [2:0] PH_PIXELS = 3'd4;
  localparam logic [2:0] PH_IDLE   = 3'd5;

  localparam logic [15:0] END_MARK    = 16'hFFFF;
  localparam logic [3:0]  HEADER_LAST = 4'd15;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] v;
    unique case (idx)
      2'd0: v = 8'hAB;
      2'd1: v = 8'hCD;
      2'd2: v = 8'hEF;
      2'd3: v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  logic [2:0]  phase, phase_next, e_phase;
  logic [3:0]  fcnt, fcnt_next, e_fcnt;
  logic [7:0]  pend, pend_next, e_pend;
  logic [15:0] left_x, left_x_next, e_left_x;
  logic [15:0] top_y, top_y_next, e_top_y;
  logic [15:0] right_x, right_x_next, e_right_x;
  logic [16:0] img_w, img_w_next, e_img_w;
  logic [16:0] img_h, img_h_next, e_img_h;
  logic [7:0]  fill, fill_next, e_fill;
  logic [18:0] tbl_left, tbl_left_next, e_tbl_left;
  logic [16:0] cur_row, cur_row_next, e_cur_row;
  logic [17:0] cursor_x, cursor_x_next, e_cursor_x;
  logic [15:0] skip_amt, skip_amt_next, e_skip_amt;
  logic [15:0] run_left, run_left_next, e_run_left;
  logic [17:0] write_x, write_x_next, e_write_x;
  logic        sig_bad, sig_bad_next, e_sig_bad;
  logic        size_bad, size_bad_next, e_size_bad;

  // A first byte of file restarts parsing before the byte is used.
  always_comb begin
    e_phase    = first_of_file ? PH_HEADER : phase;
    e_fcnt     = first_of_file ? '0 : fcnt;
    e_pend     = first_of_file ? '0 : pend;
    e_left_x   = first_of_file ? '0 : left_x;
    e_top_y    = first_of_file ? '0 : top_y;
    e_right_x  = first_of_file ? '0 : right_x;
    e_img_w    = first_of_file ? '0 : img_w;
    e_img_h    = first_of_file ? '0 : img_h;
    e_fill     = first_of_file ? '0 : fill;
    e_tbl_left = first_of_file ? '0 : tbl_left;
    e_cur_row  = first_of_file ? '0 : cur_row;
    e_cursor_x = first_of_file ? '0 : cursor_x;
    e_skip_amt = first_of_file ? '0 : skip_amt;
    e_run_left = first_of_file ? '0 : run_left;
    e_write_x  = first_of_file ? '0 : write_x;
    e_sig_bad  = first_of_file ? 1'b0 : sig_bad;
    e_size_bad = first_of_file ? 1'b0 : size_bad;
  end

  logic [15:0] word;
  logic [17:0] wsum;
  logic [17:0] hsum;
  logic        sz_bad;
  logic        sig_bad_now;
  logic [16:0] row_inc;
  logic        last_row;
  logic [17:0] wx_run;
  logic [17:0] cur_run;
  logic        hit;
  logic [15:0] run_dec;
  logic        end_row;

  always_comb begin
    word = word_big_endian ? {e_pend, data_byte} : {data_byte, e_pend};
    wsum = {2'b0, e_right_x} - {2'b0, e_left_x} + 18'd1;
    hsum = {2'b0, word} - {2'b0, e_top_y} + 18'd1;
    sz_bad = wsum[17] || (wsum == '0) || hsum[17] || (hsum == '0);
    sig_bad_now = e_sig_bad || (data_byte != sig_byte(e_fcnt[1:0]));
    row_inc = e_cur_row + 17'd1;
    last_row = row_inc >= e_img_h;
    wx_run = e_cursor_x + {2'b0, e_skip_amt};
    cur_run = wx_run + {2'b0, word};
    hit = e_write_x < {1'b0, e_img_w};
    run_dec = (e_run_left != '0) ? e_run_left - 16'd1 : e_run_left;
  end

  always_comb begin
    phase_next    = e_phase;
    fcnt_next     = e_fcnt;
    pend_next     = e_pend;
    left_x_next   = e_left_x;
    top_y_next    = e_top_y;
    right_x_next  = e_right_x;
    img_w_next    = e_img_w;
    img_h_next    = e_img_h;
    fill_next     = e_fill;
    tbl_left_next = e_tbl_left;
    cur_row_next  = e_cur_row;
    cursor_x_next = e_cursor_x;
    skip_amt_next = e_skip_amt;
    run_left_next = e_run_left;
    write_x_next  = e_write_x;
    sig_bad_next  = e_sig_bad;
    size_bad_next = e_size_bad;
    res_valid     = 1'b0;
    res           = '0;
    end_row       = 1'b0;

    unique case (e_phase)
      PH_HEADER: begin
        fcnt_next = e_fcnt + 4'd1;
        if (!e_fcnt[3]) begin
          if (!e_fcnt[0]) begin
            pend_next = data_byte;
          end else begin
            unique case (e_fcnt[2:1])
              2'd0: left_x_next = word;
              2'd1: top_y_next = word;
              2'd2: right_x_next = word;
              default: begin
                size_bad_next = sz_bad;
                img_w_next = sz_bad ? '0 : wsum[16:0];
                img_h_next = sz_bad ? '0 : hsum[16:0];
              end
            endcase
          end
        end else if (e_fcnt == 4'd8) begin
          fill_next = data_byte;
        end else if (e_fcnt[3:2] == 2'b11) begin
          sig_bad_next = sig_bad_now;
        end
        if (e_fcnt == HEADER_LAST) begin
          fcnt_next = '0;
          res_valid = 1'b1;
          if (sig_bad_now) begin
            phase_next = PH_IDLE;
            res.kind = KIND_BAD_SIG;
          end else if (e_size_bad) begin
            phase_next = PH_IDLE;
            res.kind = KIND_BAD_SZ;
          end else begin
            phase_next = PH_TABLE;
            tbl_left_next = {e_img_h, 2'b00};
            cur_row_next = '0;
            res.kind = KIND_HEADER;
            res.row = e_img_h;
            res.col = e_img_w;
            res.pix = e_fill;
          end
        end
      end
      PH_TABLE: begin
        if (e_tbl_left != '0) begin
          tbl_left_next = e_tbl_left - 19'd1;
        end
        if (tbl_left_next == '0) begin
          phase_next = PH_SKIP;
          fcnt_next = '0;
          cursor_x_next = '0;
        end
      end
      PH_SKIP: begin
        if (!e_fcnt[0]) begin
          pend_next = data_byte;
          fcnt_next = 4'd1;
        end else begin
          fcnt_next = '0;
          if (word == END_MARK) begin
            end_row = 1'b1;
          end else begin
            skip_amt_next = word;
            phase_next = PH_RUN;
          end
        end
      end
      PH_RUN: begin
        if (!e_fcnt[0]) begin
          pend_next = data_byte;
          fcnt_next = 4'd1;
        end else begin
          fcnt_next = '0;
          run_left_next = word;
          write_x_next = wx_run;
          cursor_x_next = cur_run;
          if (word == '0) begin
            if (cur_run > {1'b0, e_img_w}) begin
              end_row = 1'b1;
            end else begin
              phase_next = PH_SKIP;
            end
          end else begin
            phase_next = PH_PIXELS;
          end
        end
      end
      PH_PIXELS: begin
        if (hit) begin
          res_valid = 1'b1;
          res.kind = KIND_PIXEL;
          res.row = e_cur_row;
          res.col = e_write_x[16:0];
          res.pix = data_byte;
        end
        write_x_next = e_write_x + 18'd1;
        run_left_next = run_dec;
        if (run_dec == '0) begin
          // A row that overran the width ends only if this last byte was dropped.
          if (e_cursor_x > {1'b0, e_img_w} && !hit) begin
            end_row = 1'b1;
          end else begin
            phase_next = PH_SKIP;
            fcnt_next = '0;
          end
        end
      end
      default: begin
      end
    endcase

    if (end_row) begin
      cur_row_next = row_inc;
      fcnt_next = '0;
      cursor_x_next = '0;
      res_valid = 1'b1;
      res.row = e_cur_row;
      if (last_row) begin
        phase_next = PH_IDLE;
        res.kind = KIND_IMG_END;
      end else begin
        phase_next = PH_SKIP;
        res.kind = KIND_ROW_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      fcnt     <= '0;
      pend     <= '0;
      left_x   <= '0;
      top_y    <= '0;
      right_x  <= '0;
      img_w    <= '0;
      img_h    <= '0;
      fill     <= '0;
      tbl_left <= '0;
      cur_row  <= '0;
      cursor_x <= '0;
      skip_amt <= '0;
      run_left <= '0;
      write_x  <= '0;
      sig_bad  <= 1'b0;
      size_bad <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      fcnt     <= fcnt_next;
      pend     <= pend_next;
      left_x   <= left_x_next;
      top_y    <= top_y_next;
      right_x  <= right_x_next;
      img_w    <= img_w_next;
      img_h    <= img_h_next;
      fill     <= fill_next;
      tbl_left <= tbl_left_next;
      cur_row  <= cur_row_next;
      cursor_x <= cursor_x_next;
      skip_amt <= skip_amt_next;
      run_left <= run_left_next;
      write_x  <= write_x_next;
      sig_bad  <= sig_bad_next;
      size_bad <= size_bad_next;
    end
  end

  a_word_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP || phase == PH_RUN) |-> fcnt <= 4'd1)
    else $error("word byte count out of range in segment phase");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> run_left != '0)
    else $error("pixel phase with empty run");

  a_table_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TABLE) |-> tbl_left != '0)
    else $error("row table phase with nothing left to skip");

endmodule

>>> tb/span_decode_checker.sv
module span_decode_checker import sspan_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [DataW-1:0]  s_tdata,
  input  logic [0:0]        s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [OutW-1:0]   m_tdata,
  input  logic [KindW-1:0]  m_tuser,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output int                mismatches,
  output int                outstanding
);

  typedef enum logic [2:0] {
    P_HEADER, P_TABLE, P_SKIP, P_RUN, P_PIXELS, P_DONE
  } parse_phase_t;

  localparam logic [15:0] END_MARK  = 16'hFFFF;
  localparam logic [31:0] SIGNATURE = 32'h01EFCDAB;  // AB first

  logic         big_endian;
  parse_phase_t phase;
  logic [4:0]   byte_cnt;
  logic [15:0]  word_acc, left_x, top_y, right_x, skip_len, run_len;
  logic [16:0]  img_w, img_h, row;
  logic [7:0]   fill;
  logic [18:0]  table_left;
  logic [17:0]  cursor, wr_x;
  logic         sig_bad, size_bad;
  result_t      image_events[$];

  task automatic clear_parse();
    phase = P_HEADER;
    byte_cnt = '0; word_acc = '0;
    left_x = '0; top_y = '0; right_x = '0;
    img_w = '0; img_h = '0; fill = '0;
    table_left = '0; row = '0; cursor = '0;
    skip_len = '0; run_len = '0; wr_x = '0;
    sig_bad = 1'b0; size_bad = 1'b0;
  endtask

  // Low byte of a word arrives first in little endian, high byte in big endian.
  task automatic take_word(input logic [7:0] b, input logic odd, output logic done);
    done = odd;
    if (!odd) word_acc = {8'h00, b};
    else if (big_endian) word_acc = {word_acc[7:0], b};
    else word_acc = {b, word_acc[7:0]};
  endtask

  task automatic post(input logic [KindW-1:0] k, input logic [16:0] r, input logic [16:0] c,
                      input logic [7:0] p);
    result_t e;
    e.kind = k; e.row = r; e.col = c; e.pix = p;
    image_events.push_back(e);
  endtask

  task automatic close_row();
    logic [16:0] r;
    r = row;
    row = row + 17'd1;
    byte_cnt = '0;
    cursor = '0;
    if (row >= img_h) begin
      phase = P_DONE;
      post(KIND_IMG_END, r, '0, '0);
    end else begin
      phase = P_SKIP;
      post(KIND_ROW_END, r, '0, '0);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic first);
    logic done;
    logic emitted;
    int   w, h;
    if (first) clear_parse();
    case (phase)
      P_HEADER: begin
        done = 1'b0;
        if (byte_cnt < 5'd8) take_word(b, byte_cnt[0], done);
        if (done) begin
          case (byte_cnt)
            5'd1: left_x = word_acc;
            5'd3: top_y = word_acc;
            5'd5: right_x = word_acc;
            default: begin
              // sizes are signed: a corner pair in the wrong order is a bad size
              w = int'(right_x) - int'(left_x) + 1;
              h = int'(word_acc) - int'(top_y) + 1;
              size_bad = (w <= 0) || (h <= 0);
              img_w = size_bad ? '0 : w[16:0];
              img_h = size_bad ? '0 : h[16:0];
            end
          endcase
        end else if (byte_cnt == 5'd8) begin
          fill = b;
        end else if (byte_cnt >= 5'd12 && byte_cnt < 5'd16) begin
          if (b != SIGNATURE[8*(byte_cnt-12) +: 8]) sig_bad = 1'b1;
        end
        if (byte_cnt == 5'd15) begin
          byte_cnt = '0;
          if (sig_bad) begin
            phase = P_DONE;
            post(KIND_BAD_SIG, '0, '0, '0);
          end else if (size_bad) begin
            phase = P_DONE;
            post(KIND_BAD_SZ, '0, '0, '0);
          end else begin
            phase = P_TABLE;
            table_left = {img_h, 2'b00};
            row = '0;
            post(KIND_HEADER, img_h, img_w, fill);
          end
        end else begin
          byte_cnt = byte_cnt + 5'd1;
        end
      end
      P_TABLE: begin
        if (table_left != '0) table_left = table_left - 19'd1;
        if (table_left == '0) begin
          phase = P_SKIP;
          byte_cnt = '0;
          cursor = '0;
        end
      end
      P_SKIP: begin
        take_word(b, byte_cnt[0], done);
        if (!done) begin
          byte_cnt = 5'd1;
        end else begin
          byte_cnt = '0;
          if (word_acc == END_MARK) begin
            close_row();
          end else begin
            skip_len = word_acc;
            phase = P_RUN;
          end
        end
      end
      P_RUN: begin
        take_word(b, byte_cnt[0], done);
        if (!done) begin
          byte_cnt = 5'd1;
        end else begin
          byte_cnt = '0;
          run_len = word_acc;
          wr_x = cursor + {2'b00, skip_len};
          cursor = wr_x + {2'b00, run_len};
          if (run_len == '0) begin
            if (cursor > {1'b0, img_w}) close_row();
            else phase = P_SKIP;
          end else begin
            phase = P_PIXELS;
          end
        end
      end
      P_PIXELS: begin
        // pixels at or past the width are dropped
        emitted = wr_x < {1'b0, img_w};
        if (emitted) post(KIND_PIXEL, row, wr_x[16:0], b);
        wr_x = wr_x + 18'd1;
        if (run_len != '0) run_len = run_len - 16'd1;
        if (run_len == '0) begin
          if (cursor > {1'b0, img_w} && !emitted) begin
            close_row();
          end else begin
            phase = P_SKIP;
            byte_cnt = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t got, want;
    if (rst) begin
      big_endian = 1'b0;
      clear_parse();
      image_events.delete();
      mismatches = 0;
    end else begin
      // a result never comes from the byte taken at the same edge
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.row  = m_tdata[16:0];
        got.col  = m_tdata[33:17];
        got.pix  = m_tdata[41:34];
        if (image_events.size() == 0) begin
          $display("%0t: unexpected item: expected none, got kind %0d row %0d col %0d pix %0d",
                   $time, got.kind, got.row, got.col, got.pix);
          mismatches++;
        end else begin
          want = image_events.pop_front();
          check_field("kind", int'(want.kind), int'(got.kind));
          check_field("row_index", int'(want.row), int'(got.row));
          check_field("column_index", int'(want.col), int'(got.col));
          check_field("pixel_value", int'(want.pix), int'(got.pix));
          check_field("tdata pad", 0, int'(m_tdata[47:42]));
        end
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser[0]);
      if (cfg_we) big_endian = cfg_wdata;
    end
    outstanding = image_events.size();
  end

endmodule

>>> tb/tb_sparse_span_image_decoder.sv
module tb_sparse_span_image_decoder;
  import sspan_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int HoldCycles   = 300;
  localparam int PhaseBytes   = 140;
  localparam int SettleCycles = 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DataW-1:0]  s_tdata = '0;
  logic [0:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OutW-1:0]   m_tdata;
  logic [KindW-1:0]  m_tuser;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;

  int mismatches, outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  // byte order used to lay out the words of the files being built
  logic       big_order = 1'b0;
  logic [7:0] file_bytes[$];
  logic       file_flags[$];

  sparse_span_image_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  span_decode_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_sparse_span_image_decoder: done, errors");
      $finish;
    end
  end

  // Result side: stall at random, or hold off for a long stretch when asked.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left <= HoldCycles;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one item, idling first at random; return at the falling edge after it is taken.
  task automatic push_byte(input logic [7:0] d, input logic f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    file_bytes.push_back(b);
    file_flags.push_back(1'b0);
  endtask

  task automatic put_word(input logic [15:0] v);
    if (big_order) begin
      add_byte(v[15:8]);
      add_byte(v[7:0]);
    end else begin
      add_byte(v[7:0]);
      add_byte(v[15:8]);
    end
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) push_byte(file_bytes[i], file_flags[i]);
  endtask

  // Drop valid and wait until every predicted item has come out, then let the pipe settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Build one file: mostly well-formed small images, plus bad signatures, bad sizes,
  // truncated files and loose noise bytes.
  task automatic build_file();
    int pick, w, h, left, top, right, bottom, cur, segs, skip, run, cut, k;
    logic [31:0] sig;
    pick = $urandom_range(0, 99);
    file_bytes.delete();
    file_flags.delete();
    if (pick >= 94) begin
      repeat ($urandom_range(1, 12)) begin
        file_bytes.push_back(8'($urandom_range(0, 255)));
        file_flags.push_back($urandom_range(0, 5) == 0);
      end
      return;
    end
    // keep most images tiny; now and then a huge width with rows closed by end marks
    w = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 10);
    h = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    case ($urandom_range(0, 7))
      0: left = 0;
      1: left = 65536 - w;
      default: left = $urandom_range(0, 65536 - w);
    endcase
    top = $urandom_range(0, 65536 - h);
    right = left + w - 1;
    bottom = top + h - 1;
    if (pick >= 80 && pick < 88) begin
      // reverse the width corners, the height corners, or both
      if (pick < 84 || pick >= 86) begin
        left = $urandom_range(1, 65535);
        right = $urandom_range(0, left - 1);
      end
      if (pick >= 84) begin
        top = $urandom_range(1, 65535);
        bottom = $urandom_range(0, top - 1);
      end
    end
    put_word(16'(left));
    put_word(16'(top));
    put_word(16'(right));
    put_word(16'(bottom));
    add_byte(8'($urandom_range(0, 255)));
    repeat (3) add_byte(8'($urandom_range(0, 255)));
    sig = 32'h01EFCDAB;
    if (pick >= 70 && pick < 80) begin
      k = $urandom_range(0, 3);
      sig[8*k +: 8] = sig[8*k +: 8] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < 4; i++) add_byte(sig[8*i +: 8]);
    file_flags[0] = 1'b1;
    if (pick >= 70 && pick < 88) return;
    repeat (4 * h) add_byte(8'($urandom_range(0, 255)));
    for (int r = 0; r < h; r++) begin
      cur = 0;
      segs = 0;
      // mirror the row loop: a row closes by itself once the cursor passes the width
      while (cur <= w) begin
        if (segs >= 4 || $urandom_range(0, 4) == 0) begin
          put_word(16'hFFFF);
          break;
        end
        skip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65534) : $urandom_range(0, 3);
        run = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        put_word(16'(skip));
        put_word(16'(run));
        repeat (run) add_byte(8'($urandom_range(0, 255)));
        cur = cur + skip + run;
        segs++;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
    end
    if (pick >= 88) begin
      // cut the file short; the next file restarts parsing
      cut = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > cut) begin
        void'(file_bytes.pop_back());
        void'(file_flags.pop_back());
      end
    end
  endtask

  initial begin
    int sent;
    bit paused;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: a 2x1 image sent with no start-of-file mark right after reset.
    // Its run of three pixels drops the last one, which also ends the image.
    file_bytes.delete();
    file_flags.delete();
    put_word(16'h0000);
    put_word(16'h0000);
    put_word(16'h0001);
    put_word(16'h0000);
    add_byte(8'hFF);
    repeat (3) add_byte(8'h00);
    add_byte(8'hAB);
    add_byte(8'hCD);
    add_byte(8'hEF);
    add_byte(8'h01);
    repeat (4) add_byte(8'hFF);
    put_word(16'h0000);
    put_word(16'h0003);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h5A);
    send_file();

    // Random phases: both byte orders under each idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      big_order = ph[0];
      cfg_we <= 1'b1;
      cfg_wdata <= big_order;
      @(negedge clk);
      cfg_we <= 1'b0;
      case (ph >> 1)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      // hold the result side off while bytes keep coming at full rate
      if (ph == 1) hold_requests++;
      sent = 0;
      while (sent < PhaseBytes) begin
        build_file();
        send_file();
        sent += file_bytes.size();
        // pause the sender once until every result is out
        if (ph == 4 && !paused && sent > PhaseBytes / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("tb_sparse_span_image_decoder: done, clean");
    end else begin
      $display("tb_sparse_span_image_decoder: done, errors");
    end
    $finish;
  end

endmodule
